[design/clx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and functions of the Coolix IR frame encoder.
package clx_pkg;

   localparam int unsigned UNIT_W       = 4;
   localparam int unsigned BIT_IDX_W    = 6;
   localparam int unsigned WORD_W       = 24;
   localparam int unsigned FRAMES_W     = 2;
   localparam int unsigned MODE_W       = 3;
   localparam int unsigned TEMP_W       = 8;
   localparam int unsigned GRAY_W       = 4;

   localparam int unsigned HEADER_UNITS_DEF    = 8;
   localparam int unsigned GAP_UNITS_DEF       = 9;
   localparam int unsigned ONE_SPACE_UNITS_DEF = 3;

   localparam logic [BIT_IDX_W-1:0] TOTAL_BITS       = 6'd48;
   localparam logic [FRAMES_W-1:0]  EXTRA_FRAMES_RST = 2'd1;

   localparam logic [WORD_W-1:0] WORD_OFF        = 24'hB27BE0;
   localparam logic [WORD_W-1:0] WORD_DEFAULT    = 24'hB2BFC8;
   localparam logic [WORD_W-1:0] WORD_AUTO_FAN   = 24'hB21FC8;
   localparam logic [WORD_W-1:0] MODE_FIELD_MASK = 24'h00000C;
   localparam logic [WORD_W-1:0] TEMP_FIELD_MASK = 24'h0000F0;
   localparam logic [1:0]        MODE_BITS_COOL  = 2'd0;
   localparam logic [1:0]        MODE_BITS_HEAT  = 2'd3;
   localparam logic [TEMP_W-1:0] TEMP_LOW        = 8'd17;
   localparam logic [TEMP_W-1:0] TEMP_HIGH       = 8'd30;

   localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COOL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HEAT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AUTO = 3'd3;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_MARK  = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_MARK  = 3'd3,
      PH_BIT_SPACE = 3'd4,
      PH_FOOT_MARK = 3'd5,
      PH_GAP       = 3'd6
   } phase_type;

   typedef struct packed {
      logic              req_type;
      logic [MODE_W-1:0] mode;
      logic [TEMP_W-1:0] target_temp;
   } req_type_type;

   typedef struct packed {
      logic              ir_level;
      logic              busy_res;
      logic              rejected;
      logic              done_res;
      logic [WORD_W-1:0] code_word;
   } rsp_type;

   // Temperature step 0..13 to the 4-bit code carried in bits 7:4.
   function automatic logic [GRAY_W-1:0] temp_gray(input logic [GRAY_W-1:0] step);
      logic [GRAY_W-1:0] code;
      case (step)
         4'd0:    code = 4'h0;
         4'd1:    code = 4'h1;
         4'd2:    code = 4'h3;
         4'd3:    code = 4'h2;
         4'd4:    code = 4'h6;
         4'd5:    code = 4'h7;
         4'd6:    code = 4'h5;
         4'd7:    code = 4'h4;
         4'd8:    code = 4'hC;
         4'd9:    code = 4'hD;
         4'd10:   code = 4'h9;
         4'd11:   code = 4'h8;
         4'd12:   code = 4'hA;
         4'd13:   code = 4'hB;
         default: code = 4'h0;
      endcase
      return code;
   endfunction

endpackage

[design/coolix_ir_frame_encoder.sv]
`timescale 1ns / 1ps
// Top level of the Coolix IR frame encoder: frame sequencer and result register.
//
//   channel | ports                            | carries
//   req     | req_valid, req_ready, req_data   | start request or one time-unit tick
//   rsp     | rsp_valid, rsp_ready, rsp_data   | envelope level and status, one per item
//   csr     | csr_valid, csr_ready, csr_data   | extra_frames register write
//
// Each item is handled at acceptance: the sequencer state and the output register are both
// loaded from it, so one item per clock is sustained while rsp_ready stays high.
// An item is accepted whenever the output register is empty or being drained.
// Synchronous reset idles the sequencer, clears the code word and sets extra_frames to 1.
// A stalled result holds in the output register and blocks only further requests.
module coolix_ir_frame_encoder #(
   parameter int unsigned HEADER_UNITS    = clx_pkg::HEADER_UNITS_DEF,
   parameter int unsigned GAP_UNITS       = clx_pkg::GAP_UNITS_DEF,
   parameter int unsigned ONE_SPACE_UNITS = clx_pkg::ONE_SPACE_UNITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  clx_pkg::req_type_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output clx_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [clx_pkg::FRAMES_W-1:0]  csr_data
);
   import clx_pkg::*;

   localparam logic [UNIT_W-1:0] HDR_LEN = UNIT_W'(HEADER_UNITS);
   localparam logic [UNIT_W-1:0] GAP_LEN = UNIT_W'(GAP_UNITS);
   localparam logic [UNIT_W-1:0] ONE_LEN = UNIT_W'(ONE_SPACE_UNITS);

   phase_type              phase_ff, phase_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [BIT_IDX_W-1:0]   bit_index_ff, bit_index_in;
   logic [UNIT_W-1:0]      unit_count_ff, unit_count_in;
   logic [FRAMES_W-1:0]    frames_left_ff, frames_left_in;
   logic [FRAMES_W-1:0]    extra_frames_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   active;
   logic [WORD_W-1:0]      new_word;
   logic [UNIT_W-1:0]      len;
   logic [UNIT_W:0]        count_next;
   logic [BIT_IDX_W:0]     bit_next;
   logic [7:0]             seg;
   logic                   cur_bit;
   logic                   level;
   logic                   rej;
   logic                   done;
   phase_type              follow;

   clx_word_build u_word_build (
      .mode        (req_data.mode),
      .target_temp (req_data.target_temp),
      .word        (new_word)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign active     = (phase_ff != PH_IDLE);

   // Bit being sent: byte pairs are word bytes 2,1,0, each followed by its inverse.
   always_comb begin
      case (bit_index_ff[5:4])
         2'd0:    seg = word_ff[23:16];
         2'd1:    seg = word_ff[15:8];
         default: seg = word_ff[7:0];
      endcase
      cur_bit = seg[~bit_index_ff[2:0]] ^ bit_index_ff[3];
   end

   always_comb begin
      len    = 4'd1;
      level  = 1'b0;
      follow = phase_ff;
      unique case (phase_ff)
         PH_HDR_MARK: begin
            level  = 1'b1;
            len    = HDR_LEN;
            follow = PH_HDR_SPACE;
         end
         PH_HDR_SPACE: begin
            len    = HDR_LEN;
            follow = PH_BIT_MARK;
         end
         PH_BIT_MARK: begin
            level  = 1'b1;
            follow = PH_BIT_SPACE;
         end
         PH_BIT_SPACE: begin
            len    = cur_bit ? ONE_LEN : 4'd1;
            follow = (bit_next >= {1'b0, TOTAL_BITS}) ? PH_FOOT_MARK : PH_BIT_MARK;
         end
         PH_FOOT_MARK: begin
            level  = 1'b1;
            follow = PH_GAP;
         end
         PH_GAP: begin
            len    = GAP_LEN;
            follow = PH_HDR_MARK;
         end
         default: begin
            len    = 4'd1;
            follow = PH_IDLE;
         end
      endcase
   end

   assign count_next = {1'b0, unit_count_ff} + 5'd1;
   assign bit_next   = {1'b0, bit_index_ff} + 7'd1;

   always_comb begin
      phase_in       = phase_ff;
      word_in        = word_ff;
      bit_index_in   = bit_index_ff;
      unit_count_in  = unit_count_ff;
      frames_left_in = frames_left_ff;
      rej            = 1'b0;
      done           = 1'b0;
      if (req_accept) begin
         if (req_data.req_type == REQ_START) begin
            if (active) begin
               rej = 1'b1;
            end else begin
               word_in        = new_word;
               phase_in       = PH_HDR_MARK;
               bit_index_in   = '0;
               unit_count_in  = '0;
               frames_left_in = extra_frames_ff;
            end
         end else if (active) begin
            if (count_next >= {1'b0, len}) begin
               unit_count_in = '0;
               phase_in      = follow;
               case (phase_ff)
                  PH_BIT_SPACE: bit_index_in = bit_next[BIT_IDX_W-1:0];
                  PH_HDR_SPACE: bit_index_in = '0;
                  PH_GAP: begin
                     if (frames_left_ff == '0) begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        frames_left_in = frames_left_ff - 2'd1;
                     end
                  end
                  default: ;
               endcase
            end else begin
               unit_count_in = count_next[UNIT_W-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_data_in.ir_level  = (req_data.req_type == REQ_TICK) && active && level;
      rsp_data_in.busy_res  = (phase_in != PH_IDLE);
      rsp_data_in.rejected  = rej;
      rsp_data_in.done_res  = done;
      rsp_data_in.code_word = word_in;
      rsp_valid_in          = req_accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         word_ff         <= '0;
         bit_index_ff    <= '0;
         unit_count_ff   <= '0;
         frames_left_ff  <= '0;
         extra_frames_ff <= EXTRA_FRAMES_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         word_ff        <= word_in;
         bit_index_ff   <= bit_index_in;
         unit_count_ff  <= unit_count_in;
         frames_left_ff <= frames_left_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            extra_frames_ff <= csr_data;
         end
      end
   end

   // Load the result only on an accepted item; hold it otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/clx_word_build.sv]
`timescale 1ns / 1ps
// Code word builder: mode and target temperature to the 24-bit frame word.
module clx_word_build (
   input  logic [clx_pkg::MODE_W-1:0] mode,
   input  logic [clx_pkg::TEMP_W-1:0] target_temp,
   output logic [clx_pkg::WORD_W-1:0] word
);
   import clx_pkg::*;

   logic [TEMP_W-1:0] temp_off;
   logic [GRAY_W-1:0] step;
   logic [WORD_W-1:0] base;
   logic              is_off;

   always_comb begin
      // Saturate to 17..30, then take the offset from 17.
      temp_off = target_temp - TEMP_LOW;
      if (target_temp < TEMP_LOW) begin
         step = '0;
      end else if (target_temp > TEMP_HIGH) begin
         step = GRAY_W'(TEMP_HIGH - TEMP_LOW);
      end else begin
         step = temp_off[GRAY_W-1:0];
      end
   end

   always_comb begin
      is_off = 1'b0;
      unique case (mode)
         MODE_COOL: base = (WORD_DEFAULT & ~MODE_FIELD_MASK)
                           | {{(WORD_W-4){1'b0}}, MODE_BITS_COOL, 2'b00};
         MODE_HEAT: base = (WORD_DEFAULT & ~MODE_FIELD_MASK)
                           | {{(WORD_W-4){1'b0}}, MODE_BITS_HEAT, 2'b00};
         MODE_AUTO: base = WORD_AUTO_FAN;
         default: begin
            base   = WORD_OFF;
            is_off = 1'b1;
         end
      endcase
   end

   assign word = is_off ? WORD_OFF
               : ((base & ~TEMP_FIELD_MASK) | {{(WORD_W-8){1'b0}}, temp_gray(step), 4'h0});

endmodule

[design/clx_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the Coolix IR frame encoder, bound to the top level.
module clx_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input clx_pkg::rsp_type rsp_data
);
   import clx_pkg::*;

   // A rejected start leaves the running transmission in place.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res && !rsp_data.ir_level
                                         && !rsp_data.done_res)
      else $error("rejected item without a running transmission");

   // The last gap unit ends the transmission and is a space.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && !rsp_data.ir_level)
      else $error("done item still busy or marking");

   // A mark only ever falls inside a transmission.
   a_mark_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ir_level |-> rsp_data.busy_res)
      else $error("mark outside a transmission");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind coolix_ir_frame_encoder clx_checker u_clx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
